### src/assert_macros.svh
// Assertion macros used by the RTL in this folder.
// Needs nothing else; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### src/tqrsd_pkg.sv
// Constants and codes for the typed queue dispatcher.
// No dependencies; used by tqrsd_ram users and the top level.
package tqrsd_pkg;

  localparam int NUM_TYPES     = 4;
  localparam int QUEUE_DEPTH   = 64;
  localparam int GROUP_WORKERS = 8;

  localparam int TYPE_W   = 2;                        // request type field
  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);      // ring slot
  localparam int CNT_W    = SLOT_W + 1;               // counts mod 2*depth
  localparam int RAM_AW   = TYPE_W + SLOT_W;
  localparam int RAM_DEPTH = NUM_TYPES * QUEUE_DEPTH;
  localparam int REQ_W    = 16;
  localparam int WID_W    = 3;
  localparam int WIDX_W   = 10;
  localparam int TCNT_W   = 3;                        // active_types field
  localparam int GSIZE_W  = 4;                        // group_size field
  localparam int PREFS_W  = 56;
  localparam int LIST_W   = 24;
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int REGIDX_W = 3;

  // occupancy of a full ring
  localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(QUEUE_DEPTH);

  // Register indexes (byte address / 8)
  localparam logic [REGIDX_W-1:0] REG_PREFS0       = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_PREFS1       = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_PREFS2       = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_PREFS3       = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_WORKER_BASE  = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_GROUP_SIZE   = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_ACTIVE_TYPES = 3'd6;

  localparam logic [GSIZE_W-1:0] RST_GROUP_SIZE   = GSIZE_W'(GROUP_WORKERS);
  localparam logic [TCNT_W-1:0]  RST_ACTIVE_TYPES = TCNT_W'(NUM_TYPES);

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_FREE   = 1'b1;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_REJECT   = 1'b1;

endpackage

### src/tqrsd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tqrsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/typed_queue_reserved_steal_dispatch.sv
// Typed request queues dispatching onto a worker group with reserved/stealable lists.
// Depends on tqrsd_pkg, tqrsd_ram and assert_macros.svh.
//
// An item is taken when start is high and busy is low. Arrivals append a
// 16-bit handle to their type's ring (64 entries per type, held in one
// 256 x 16 RAM); a full ring gives a reject beat. Worker-free items set the
// worker's bit in the free mask if it lies within the group. After each item
// the sequencer walks types 0 .. n-1 (n = active_types, clamped to four): per
// type it looks for a free worker, and each dispatch adds a RAM read of the
// oldest handle before the same type is looked at again. busy stays high
// through the walk and a final flush state; at most eight dispatches (one per
// worker) are made per item. Each result beat is on the ports for one cycle,
// marked by result_valid_o; a beat is held back until the next dispatch is
// read or the walk ends, so last_o can be set on the final one. The receiver
// cannot stall, so it must take every beat as it appears. The final beat
// of an item arrives on the cycle busy falls. The RAM has no reset and
// needs no clearing pass: only written slots are ever read.
// Configuration (64-bit APB, register i at byte 8*i) must be written only while busy
// is low; the block itself does not enforce this. Writing group_size reloads the free mask.
`include "assert_macros.svh"

module typed_queue_reserved_steal_dispatch (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command port
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic [tqrsd_pkg::TYPE_W-1:0]        rtype_i,
  input  logic [tqrsd_pkg::REQ_W-1:0]         request_id_i,
  input  logic [tqrsd_pkg::WID_W-1:0]         worker_id_i,
  // results
  output logic                                result_valid_o,
  output logic                                kind_o,
  output logic [tqrsd_pkg::WIDX_W-1:0]        worker_index_o,
  output logic [tqrsd_pkg::TYPE_W-1:0]        out_type_o,
  output logic [tqrsd_pkg::REQ_W-1:0]         out_request_o,
  output logic                                last_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tqrsd_pkg::PADDR_W-1:0]       paddr,
  input  logic [tqrsd_pkg::PDATA_W-1:0]       pwdata,
  output logic [tqrsd_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ, ST_FLUSH} state_e;

  // Mask with the low min(gs, GROUP_WORKERS) bits set
  function automatic logic [tqrsd_pkg::GROUP_WORKERS-1:0] grp_mask_f(
    input logic [tqrsd_pkg::GSIZE_W-1:0] gs
  );
    logic [tqrsd_pkg::GSIZE_W-1:0]     g;
    logic [tqrsd_pkg::GROUP_WORKERS:0] m;
    g = (gs > tqrsd_pkg::GSIZE_W'(tqrsd_pkg::GROUP_WORKERS)) ?
        tqrsd_pkg::GSIZE_W'(tqrsd_pkg::GROUP_WORKERS) : gs;
    m = ((tqrsd_pkg::GROUP_WORKERS+1)'(1) << g) - (tqrsd_pkg::GROUP_WORKERS+1)'(1);
    return m[tqrsd_pkg::GROUP_WORKERS-1:0];
  endfunction

  // First free worker of a packed list: {found, id}
  function automatic logic [tqrsd_pkg::WID_W:0] pick_f(
    input logic [tqrsd_pkg::LIST_W-1:0]        ids,
    input logic [3:0]                          cnt,
    input logic [tqrsd_pkg::GROUP_WORKERS-1:0] fm
  );
    logic                          found;
    logic [tqrsd_pkg::WID_W-1:0]   id;
    logic [tqrsd_pkg::WID_W-1:0]   w;
    found = 1'b0;
    w     = '0;
    for (int i = 0; i < 8; i++) begin
      id = ids[3*i +: 3];
      if (!found && (4'(i) < cnt) && fm[id]) begin
        found = 1'b1;
        w     = id;
      end
    end
    return {found, w};
  endfunction

  // configuration registers
  logic [tqrsd_pkg::PREFS_W-1:0] prefs0_q, prefs0_d, prefs1_q, prefs1_d;
  logic [tqrsd_pkg::PREFS_W-1:0] prefs2_q, prefs2_d, prefs3_q, prefs3_d;
  logic [tqrsd_pkg::WIDX_W-1:0]  base_q, base_d;
  logic [tqrsd_pkg::GSIZE_W-1:0] group_q, group_d;
  logic [tqrsd_pkg::TCNT_W-1:0]  active_q, active_d;

  // queue and worker state
  logic [tqrsd_pkg::CNT_W-1:0]         head_q [tqrsd_pkg::NUM_TYPES];
  logic [tqrsd_pkg::CNT_W-1:0]         head_d [tqrsd_pkg::NUM_TYPES];
  logic [tqrsd_pkg::CNT_W-1:0]         tail_q [tqrsd_pkg::NUM_TYPES];
  logic [tqrsd_pkg::CNT_W-1:0]         tail_d [tqrsd_pkg::NUM_TYPES];
  logic [tqrsd_pkg::GROUP_WORKERS-1:0] free_q, free_d;

  // sequencer
  state_e                       state_q, state_d;
  logic [tqrsd_pkg::TCNT_W-1:0] t_q, t_d;
  logic [tqrsd_pkg::WID_W-1:0]  w_q, w_d;

  // held-back beat
  logic                          pend_v_q, pend_v_d;
  logic                          pend_kind_q, pend_kind_d;
  logic [tqrsd_pkg::WIDX_W-1:0]  pend_widx_q, pend_widx_d;
  logic [tqrsd_pkg::TYPE_W-1:0]  pend_type_q, pend_type_d;
  logic [tqrsd_pkg::REQ_W-1:0]   pend_req_q, pend_req_d;

  // output beat
  logic                          out_v_q, out_v_d;
  logic                          kind_q, kind_d;
  logic [tqrsd_pkg::WIDX_W-1:0]  widx_q, widx_d;
  logic [tqrsd_pkg::TYPE_W-1:0]  otype_q, otype_d;
  logic [tqrsd_pkg::REQ_W-1:0]   oreq_q, oreq_d;
  logic                          last_q, last_d;

  // combinational helpers
  logic                            cfg_we;
  logic [tqrsd_pkg::REGIDX_W-1:0]  reg_idx;
  logic [tqrsd_pkg::GSIZE_W-1:0]   eff_grp;
  logic [tqrsd_pkg::TCNT_W-1:0]    n_types;
  logic [tqrsd_pkg::TYPE_W-1:0]    q_idx;
  logic [tqrsd_pkg::CNT_W-1:0]     head_sel, tail_sel, occ;
  logic [tqrsd_pkg::PREFS_W-1:0]   prefs_sel;
  logic [tqrsd_pkg::WID_W:0]       res_pick, st_pick;
  logic                            have_w;
  logic [tqrsd_pkg::WID_W-1:0]     w_sel;

  // RAM ports
  logic                            ram_we, ram_re;
  logic [tqrsd_pkg::RAM_AW-1:0]    ram_waddr, ram_raddr;
  logic [tqrsd_pkg::REQ_W-1:0]     ram_rdata;

  tqrsd_ram #(
    .WIDTH (tqrsd_pkg::REQ_W),
    .DEPTH (tqrsd_pkg::RAM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (request_id_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[tqrsd_pkg::PADDR_W-1 -: tqrsd_pkg::REGIDX_W];

  always_comb begin
    case (reg_idx)
      tqrsd_pkg::REG_PREFS0:       prdata = tqrsd_pkg::PDATA_W'(prefs0_q);
      tqrsd_pkg::REG_PREFS1:       prdata = tqrsd_pkg::PDATA_W'(prefs1_q);
      tqrsd_pkg::REG_PREFS2:       prdata = tqrsd_pkg::PDATA_W'(prefs2_q);
      tqrsd_pkg::REG_PREFS3:       prdata = tqrsd_pkg::PDATA_W'(prefs3_q);
      tqrsd_pkg::REG_WORKER_BASE:  prdata = tqrsd_pkg::PDATA_W'(base_q);
      tqrsd_pkg::REG_GROUP_SIZE:   prdata = tqrsd_pkg::PDATA_W'(group_q);
      tqrsd_pkg::REG_ACTIVE_TYPES: prdata = tqrsd_pkg::PDATA_W'(active_q);
      default:                     prdata = '0;
    endcase
  end

  // Effective limits: oversized settings clamp to the built sizes
  assign eff_grp = (group_q > tqrsd_pkg::GSIZE_W'(tqrsd_pkg::GROUP_WORKERS)) ?
                   tqrsd_pkg::GSIZE_W'(tqrsd_pkg::GROUP_WORKERS) : group_q;
  assign n_types = (active_q > tqrsd_pkg::TCNT_W'(tqrsd_pkg::NUM_TYPES)) ?
                   tqrsd_pkg::TCNT_W'(tqrsd_pkg::NUM_TYPES) : active_q;

  // One counter pair is looked at per cycle: arriving type when idle,
  // walked type otherwise.
  assign q_idx    = (state_q == ST_IDLE) ? rtype_i : t_q[tqrsd_pkg::TYPE_W-1:0];
  assign head_sel = head_q[q_idx];
  assign tail_sel = tail_q[q_idx];
  assign occ      = head_sel - tail_sel;

  always_comb begin
    case (t_q[tqrsd_pkg::TYPE_W-1:0])
      2'd0:    prefs_sel = prefs0_q;
      2'd1:    prefs_sel = prefs1_q;
      2'd2:    prefs_sel = prefs2_q;
      default: prefs_sel = prefs3_q;
    endcase
  end

  // Reserved list first, stealable list as fall-back
  assign res_pick = pick_f(prefs_sel[27:4],  prefs_sel[3:0],   free_q);
  assign st_pick  = pick_f(prefs_sel[55:32], prefs_sel[31:28], free_q);
  assign have_w   = res_pick[tqrsd_pkg::WID_W] | st_pick[tqrsd_pkg::WID_W];
  assign w_sel    = res_pick[tqrsd_pkg::WID_W] ? res_pick[tqrsd_pkg::WID_W-1:0]
                                               : st_pick[tqrsd_pkg::WID_W-1:0];

  assign ram_waddr = {rtype_i, head_sel[tqrsd_pkg::SLOT_W-1:0]};
  assign ram_raddr = {t_q[tqrsd_pkg::TYPE_W-1:0], tail_sel[tqrsd_pkg::SLOT_W-1:0]};

  always_comb begin
    prefs0_d    = prefs0_q;
    prefs1_d    = prefs1_q;
    prefs2_d    = prefs2_q;
    prefs3_d    = prefs3_q;
    base_d      = base_q;
    group_d     = group_q;
    active_d    = active_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    state_d     = state_q;
    t_d         = t_q;
    w_d         = w_q;
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_widx_d = pend_widx_q;
    pend_type_d = pend_type_q;
    pend_req_d  = pend_req_q;
    out_v_d     = 1'b0;
    kind_d      = kind_q;
    widx_d      = widx_q;
    otype_d     = otype_q;
    oreq_d      = oreq_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (cfg_we) begin
      case (reg_idx)
        tqrsd_pkg::REG_PREFS0:       prefs0_d = pwdata[tqrsd_pkg::PREFS_W-1:0];
        tqrsd_pkg::REG_PREFS1:       prefs1_d = pwdata[tqrsd_pkg::PREFS_W-1:0];
        tqrsd_pkg::REG_PREFS2:       prefs2_d = pwdata[tqrsd_pkg::PREFS_W-1:0];
        tqrsd_pkg::REG_PREFS3:       prefs3_d = pwdata[tqrsd_pkg::PREFS_W-1:0];
        tqrsd_pkg::REG_WORKER_BASE:  base_d   = pwdata[tqrsd_pkg::WIDX_W-1:0];
        tqrsd_pkg::REG_GROUP_SIZE: begin
          group_d = pwdata[tqrsd_pkg::GSIZE_W-1:0];
          free_d  = grp_mask_f(pwdata[tqrsd_pkg::GSIZE_W-1:0]);
        end
        tqrsd_pkg::REG_ACTIVE_TYPES: active_d = pwdata[tqrsd_pkg::TCNT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          t_d      = '0;
          state_d  = ST_SCAN;
          pend_v_d = 1'b0;
          if (mode_i == tqrsd_pkg::MODE_ARRIVE) begin
            if (occ >= tqrsd_pkg::RING_FULL) begin
              // ring full: reject beat goes out ahead of any dispatch
              pend_v_d    = 1'b1;
              pend_kind_d = tqrsd_pkg::KIND_REJECT;
              pend_widx_d = '0;
              pend_type_d = rtype_i;
              pend_req_d  = request_id_i;
            end else begin
              ram_we        = 1'b1;
              head_d[q_idx] = head_sel + tqrsd_pkg::CNT_W'(1);
            end
          end else if ({1'b0, worker_id_i} < eff_grp) begin
            free_d[worker_id_i] = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (t_q >= n_types) begin
          state_d = ST_FLUSH;
        end else if ((occ != '0) && have_w) begin
          // claim the worker now, fetch the oldest handle
          ram_re        = 1'b1;
          tail_d[q_idx] = tail_sel + tqrsd_pkg::CNT_W'(1);
          free_d[w_sel] = 1'b0;
          w_d           = w_sel;
          state_d       = ST_READ;
        end else begin
          t_d = t_q + tqrsd_pkg::TCNT_W'(1);
        end
      end
      ST_READ: begin
        if (pend_v_q) begin
          out_v_d = 1'b1;
          kind_d  = pend_kind_q;
          widx_d  = pend_widx_q;
          otype_d = pend_type_q;
          oreq_d  = pend_req_q;
          last_d  = 1'b0;
        end
        pend_v_d    = 1'b1;
        pend_kind_d = tqrsd_pkg::KIND_DISPATCH;
        pend_widx_d = base_q + tqrsd_pkg::WIDX_W'(w_q);
        pend_type_d = t_q[tqrsd_pkg::TYPE_W-1:0];
        pend_req_d  = ram_rdata;
        state_d     = ST_SCAN;
      end
      ST_FLUSH: begin
        if (pend_v_q) begin
          out_v_d = 1'b1;
          kind_d  = pend_kind_q;
          widx_d  = pend_widx_q;
          otype_d = pend_type_q;
          oreq_d  = pend_req_q;
          last_d  = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefs0_q    <= '0;
      prefs1_q    <= '0;
      prefs2_q    <= '0;
      prefs3_q    <= '0;
      base_q      <= '0;
      group_q     <= tqrsd_pkg::RST_GROUP_SIZE;
      active_q    <= tqrsd_pkg::RST_ACTIVE_TYPES;
      for (int i = 0; i < tqrsd_pkg::NUM_TYPES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      free_q      <= grp_mask_f(tqrsd_pkg::RST_GROUP_SIZE);
      state_q     <= ST_IDLE;
      t_q         <= '0;
      w_q         <= '0;
      pend_v_q    <= 1'b0;
      pend_kind_q <= 1'b0;
      pend_widx_q <= '0;
      pend_type_q <= '0;
      pend_req_q  <= '0;
      out_v_q     <= 1'b0;
      kind_q      <= 1'b0;
      widx_q      <= '0;
      otype_q     <= '0;
      oreq_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      prefs0_q    <= prefs0_d;
      prefs1_q    <= prefs1_d;
      prefs2_q    <= prefs2_d;
      prefs3_q    <= prefs3_d;
      base_q      <= base_d;
      group_q     <= group_d;
      active_q    <= active_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      state_q     <= state_d;
      t_q         <= t_d;
      w_q         <= w_d;
      pend_v_q    <= pend_v_d;
      pend_kind_q <= pend_kind_d;
      pend_widx_q <= pend_widx_d;
      pend_type_q <= pend_type_d;
      pend_req_q  <= pend_req_d;
      out_v_q     <= out_v_d;
      kind_q      <= kind_d;
      widx_q      <= widx_d;
      otype_q     <= otype_d;
      oreq_q      <= oreq_d;
      last_q      <= last_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_v_q;
  assign kind_o         = kind_q;
  assign worker_index_o = widx_q;
  assign out_type_o     = otype_q;
  assign out_request_o  = oreq_q;
  assign last_o         = last_q;

  `ASSERT_ON_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "no busy after start")
  `ASSERT_ON_CLK(a_last_gap, clk_i, rst_ni, (result_valid_o && last_o) |=> !result_valid_o, "late beat")
  `ASSERT_ON_CLK(a_claimed, clk_i, rst_ni, (state_q == ST_READ) |-> !free_q[w_q], "claim lost")
  `ASSERT_ON_CLK(a_occ_bound, clk_i, rst_ni, occ <= tqrsd_pkg::RING_FULL, "ring overfilled")
  `ASSERT_NEVER(a_ram_clash, clk_i, rst_ni, ram_we && ram_re, "queue RAM read and write together")

endmodule
